>>> hw/rtl/gcc_pkg.sv
package gcc_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int APB_AW = 2;

  localparam logic [APB_AW-1:0] REG_NODE_COUNT = 2'd0;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADD_WR = 4'b0010,
    ST_BFS    = 4'b0100,
    ST_FIN    = 4'b1000
  } state_t;

endpackage

>>> hw/rtl/gcc_ram.sv
module gcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/graph_cycle_check_unit.sv
// Graph cycle check unit.
// Holds a directed graph as an adjacency bit matrix, one row per node in a
// single-port-read row RAM, and answers whether a proposed edge would close
// a cycle.
// Input stream (s_*): one word per item; tuser carries the kind (clear, add
// edge, query), tdata carries source and target node. Output stream (m_*):
// one word per input word, tdata = {edge_dropped, would_cycle}.
// APB port: node_count at address 0. The user must write it only while
// the unit is idle; the unit itself has no guard for this. Clear, unused
// kinds, dropped edges and trivial queries go straight to the finish
// state; an add reads the source row and writes it back with the new
// bit; a walking query expands every node reachable from the target,
// reading one adjacency row per cycle while nodes are pending.
// One item is worked at a time; a new word is taken as soon as the previous
// one has left its working states, even while its result still sits in the
// output register. A stalled receiver holds the result and blocks only the
// completion of the next item.
// Reset: node_count 0, graph empty (row valid bits cleared), no output.
module graph_cycle_check_unit
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  // APB
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,  // [5:0] source_node, [11:6] target_node
  input  logic [1:0]        s_tuser,  // [1:0] kind
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata   // [0] would_cycle, [1] edge_dropped
);

  localparam int AW = $clog2(MAX_NODES);

  state_t state;

  logic [CNT_W-1:0]     node_count;
  logic [CNT_W-1:0]     eff_cnt;
  logic [MAX_NODES-1:0] node_mask;

  logic [NODE_W-1:0]    in_src;
  logic [NODE_W-1:0]    in_dst;
  logic                 in_ok;
  logic                 s_acc;

  logic [AW-1:0]        q_src;
  logic [AW-1:0]        q_dst;
  logic                 res_cycle;
  logic                 res_drop;

  logic [MAX_NODES-1:0] row_valid;
  logic                 row_vld_q;
  logic [MAX_NODES-1:0] rd_data;
  logic [MAX_NODES-1:0] row_eff;
  logic [AW-1:0]        rd_addr;
  logic                 ram_we;
  logic [MAX_NODES-1:0] ram_wdata;

  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] visited_next;
  logic [MAX_NODES-1:0] pending;
  logic [MAX_NODES-1:0] pending_next;
  logic [MAX_NODES-1:0] pick_oh;
  logic [AW-1:0]        pick_idx;
  logic [MAX_NODES-1:0] new_bits;
  logic                 issue;
  logic                 rd_pending;
  logic                 walk_done;

  logic                 out_cycle;
  logic                 out_drop;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_NODE_COUNT) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  assign eff_cnt = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_mask
    assign node_mask[i] = CNT_W'(i) < eff_cnt;
  end

  // input decode
  assign in_src   = s_tdata[NODE_W-1:0];
  assign in_dst   = s_tdata[2*NODE_W-1:NODE_W];
  assign in_ok    = ({1'b0, in_src} < eff_cnt) && ({1'b0, in_dst} < eff_cnt);
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // walk: expand lowest pending node each cycle
  assign pick_oh = pending & (~pending + MAX_NODES'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | AW'(i);
      end
    end
  end

  assign issue        = (state == ST_BFS) && (pending != '0);
  assign row_eff      = row_vld_q ? rd_data : '0;
  assign new_bits     = rd_pending ? (row_eff & node_mask & ~visited) : '0;
  assign visited_next = visited | new_bits;
  assign pending_next = (pending & ~(issue ? pick_oh : '0)) | new_bits;
  assign walk_done    = (state == ST_BFS) && (pending == '0) && !rd_pending;

  // row RAM
  assign rd_addr   = (state == ST_IDLE) ? in_src[AW-1:0] : pick_idx;
  assign ram_we    = (state == ST_ADD_WR);
  assign ram_wdata = row_eff | (MAX_NODES'(1) << q_dst);

  gcc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_src),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    row_vld_q <= row_valid[rd_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_valid  <= '0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            q_src     <= in_src[AW-1:0];
            q_dst     <= in_dst[AW-1:0];
            res_drop  <= (s_tuser == KIND_ADD) && !in_ok;
            res_cycle <= (s_tuser == KIND_QUERY) && in_ok && (in_src == in_dst);
            case (s_tuser)
              KIND_CLEAR: begin
                row_valid <= '0;
                state     <= ST_FIN;
              end
              KIND_ADD: begin
                state <= in_ok ? ST_ADD_WR : ST_FIN;
              end
              KIND_QUERY: begin
                if (in_ok && in_src != in_dst) begin
                  visited <= MAX_NODES'(1) << in_dst[AW-1:0];
                  pending <= MAX_NODES'(1) << in_dst[AW-1:0];
                  state   <= ST_BFS;
                end else begin
                  state <= ST_FIN;
                end
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_ADD_WR: begin
          row_valid[q_src] <= 1'b1;
          state            <= ST_FIN;
        end
        ST_BFS: begin
          visited <= visited_next;
          pending <= pending_next;
          if (walk_done) begin
            res_cycle <= visited[q_src];
            state     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            out_cycle <= res_cycle;
            out_drop  <= res_drop;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {6'b0, out_drop, out_cycle};

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");

  a_start_visited: assert property (@(posedge clk) disable iff (rst)
    state == ST_BFS |-> visited[q_dst])
    else $error("walk start node not visited");

  a_pending_subset: assert property (@(posedge clk) disable iff (rst)
    state == ST_BFS |-> (pending & ~visited) == '0)
    else $error("pending node not marked visited");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> $past(state) == ST_BFS && state == ST_BFS)
    else $error("row read outside walk");

endmodule

>>> dv/cycle_answer_checker.sv
module cycle_answer_checker
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [15:0]       s_tdata,  // [5:0] source_node, [11:6] target_node
  input  logic [1:0]        s_tuser,  // [1:0] kind
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,  // [0] would_cycle, [1] edge_dropped
  output int                errors,
  output int                results_seen,
  output int                pending,
  output int                words_seen,
  output int                queries,
  output int                loops,
  output int                drops
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic edge_dropped;
    logic would_cycle;
  } answer_t;

  logic [63:0]      rows [MAX_NODES];
  logic [CNT_W-1:0] node_count_q;
  answer_t          answers_q [$];

  task automatic flag(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // breadth-first sweep from to_node; does it get back to from_node?
  function automatic logic closes_loop(logic [NODE_W-1:0] from_node,
                                       logic [NODE_W-1:0] to_node, int unsigned n);
    logic [63:0] seen, front, nxt, mask;
    mask  = (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
    seen  = 64'd1 << to_node;
    front = seen;
    while (front != '0) begin
      nxt = '0;
      for (int r = 0; r < MAX_NODES; r++) begin
        if (front[r]) nxt |= rows[r];
      end
      nxt &= mask & ~seen;
      seen |= nxt;
      front = nxt;
    end
    return seen[from_node];
  endfunction

  function automatic answer_t apply_word(logic [1:0] k, logic [NODE_W-1:0] a,
                                         logic [NODE_W-1:0] b);
    answer_t     ans;
    int unsigned n;
    ans = '0;
    n = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
    case (k)
      KIND_CLEAR: begin
        for (int r = 0; r < MAX_NODES; r++) rows[r] = '0;
      end
      KIND_ADD: begin
        if (a >= n || b >= n) ans.edge_dropped = 1'b1;
        else rows[a][b] = 1'b1;
      end
      KIND_QUERY: begin
        if (a < n && b < n) ans.would_cycle = (a == b) ? 1'b1 : closes_loop(a, b, n);
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    if (rst) begin
      for (int r = 0; r < MAX_NODES; r++) rows[r] = '0;
      node_count_q = '0;
      answers_q.delete();
      errors = 0;
      words_seen = 0;
      queries = 0;
      loops = 0;
      drops = 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pready && paddr == REG_NODE_COUNT) begin
        if (pwrite) node_count_q = pwdata[CNT_W-1:0];
        else if (prdata[CNT_W-1:0] !== node_count_q)
          flag($sformatf("node_count read %0d, written %0d", prdata[CNT_W-1:0],
                         node_count_q));
      end
      if (m_tvalid && m_tready) begin
        got = answer_t'(m_tdata[1:0]);
        results_seen <= results_seen + 1;
        if (answers_q.size() == 0) begin
          flag("result word with no word outstanding");
        end else begin
          want = answers_q.pop_front();
          if (got.would_cycle !== want.would_cycle)
            flag($sformatf("would_cycle %b, want %b", got.would_cycle, want.would_cycle));
          if (got.edge_dropped !== want.edge_dropped)
            flag($sformatf("edge_dropped %b, want %b", got.edge_dropped,
                           want.edge_dropped));
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_word(s_tuser, s_tdata[5:0], s_tdata[11:6]);
        answers_q.push_back(want);
        words_seen++;
        if (s_tuser == KIND_QUERY) queries++;
        loops += want.would_cycle;
        drops += want.edge_dropped;
      end
    end
    pending <= answers_q.size();
  end

endmodule

>>> dv/tb_graph_cycle_check_unit.sv
module tb_graph_cycle_check_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gcc_pkg::*;

  localparam int         MAX_NODES   = 64;
  localparam int         LIMIT       = 1000000;
  localparam int         HOLD_CYCLES = 400;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         NUM_PHASES  = 10;
  localparam logic [CNT_W-1:0] PHASE_COUNTS [NUM_PHASES] =
    '{7'd64, 7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd40, 7'd64, 7'd17, 7'd3};

  logic              clk;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;  // [5:0] source_node, [11:6] target_node
  logic [1:0]        s_tuser  = '0;  // [1:0] kind
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // [0] would_cycle, [1] edge_dropped

  logic no_gaps  = 1'b0;
  int   hold_req = 0;
  int   words_sent = 0;
  int   settings_used = 0;
  int   cycle_count = 0;
  int   chk_errors, chk_results, chk_pending, chk_words, chk_queries, chk_loops, chk_drops;

  graph_cycle_check_unit #(.MAX_NODES(MAX_NODES)) dut (.*);

  cycle_answer_checker #(.MAX_NODES(MAX_NODES)) chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .errors(chk_errors), .results_seen(chk_results), .pending(chk_pending),
    .words_seen(chk_words), .queries(chk_queries), .loops(chk_loops),
    .drops(chk_drops)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("graph_cycle_check_unit test failed");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_ack;
    hold_ack = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  task automatic send_word(input logic [1:0] k, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    while (!no_gaps && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {4'b0, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (chk_results != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_NODE_COUNT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_node_count(input logic [CNT_W-1:0] cnt);
    wait_drained();
    apb_access(1'b1, {25'b0, cnt});
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [NODE_W-1:0] pick_node(int n);
    if (n > 0 && $urandom_range(0, 9) != 0) return NODE_W'($urandom_range(0, n - 1));
    return NODE_W'($urandom_range(0, 63));
  endfunction

  initial begin
    int               n_eff, len, r;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       k;
    logic [NODE_W-1:0] a, b, last_b;
    last_b = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small graph, dup and self edges, out of range, unused kind
    set_node_count(7'd8);
    send_word(KIND_CLEAR, 6'd0, 6'd0);
    send_word(KIND_ADD, 6'd0, 6'd1);
    send_word(KIND_ADD, 6'd1, 6'd2);
    send_word(KIND_ADD, 6'd2, 6'd3);
    send_word(KIND_ADD, 6'd0, 6'd1);
    send_word(KIND_ADD, 6'd4, 6'd4);
    send_word(KIND_QUERY, 6'd3, 6'd0);
    send_word(KIND_QUERY, 6'd0, 6'd3);
    send_word(KIND_QUERY, 6'd5, 6'd5);
    send_word(KIND_QUERY, 6'd4, 6'd4);
    send_word(KIND_QUERY, 6'd8, 6'd8);
    send_word(KIND_QUERY, 6'd8, 6'd1);
    send_word(KIND_ADD, 6'd8, 6'd1);
    send_word(KIND_ADD, 6'd1, 6'd63);
    send_word(KIND_UNUSED, 6'd63, 6'd63);
    send_word(KIND_QUERY, 6'd7, 6'd0);
    // full size, edges on the highest node
    set_node_count(7'd64);
    send_word(KIND_ADD, 6'd63, 6'd0);
    send_word(KIND_ADD, 6'd0, 6'd63);
    send_word(KIND_QUERY, 6'd63, 6'd63);
    send_word(KIND_QUERY, 6'd2, 6'd63);
    send_word(KIND_QUERY, 6'd63, 6'd0);
    // shrink: stale edges beyond the count are skipped
    set_node_count(7'd2);
    send_word(KIND_QUERY, 6'd1, 6'd0);
    send_word(KIND_QUERY, 6'd0, 6'd1);
    send_word(KIND_ADD, 6'd2, 6'd0);
    send_word(KIND_CLEAR, 6'd63, 6'd63);

    for (int p = 0; p < NUM_PHASES; p++) begin
      cnt = (p == NUM_PHASES - 1) ? CNT_W'($urandom_range(0, 127)) : PHASE_COUNTS[p];
      set_node_count(cnt);
      n_eff = (cnt > MAX_NODES) ? MAX_NODES : cnt;
      no_gaps <= (p == 7);
      if (p == 0 || p == 6) hold_req <= hold_req + 1;
      if ($urandom_range(0, 1)) send_word(KIND_CLEAR, pick_node(64), pick_node(64));
      len = (n_eff < 3) ? 40 : 230;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        a = pick_node(n_eff);
        b = pick_node(n_eff);
        if (r < 2) begin
          k = KIND_CLEAR;
        end else if (r < 5) begin
          k = KIND_UNUSED;
        end else if (r < 52) begin
          k = KIND_ADD;
          if ($urandom_range(0, 9) < 4) a = last_b;  // grow a chain
          last_b = b;
        end else begin
          k = KIND_QUERY;
        end
        send_word(k, a, b);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("ran %0d words over %0d node_count settings, %0d with long output stalls",
             chk_words, settings_used, 2);
    $display("%0d queries (%0d closing a loop), %0d dropped edges, %0d results checked",
             chk_queries, chk_loops, chk_drops, chk_results);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("graph_cycle_check_unit test passed");
    end else begin
      $display("graph_cycle_check_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gcc_pkg.sv
hw/rtl/gcc_ram.sv
hw/rtl/graph_cycle_check_unit.sv
dv/cycle_answer_checker.sv
dv/tb_graph_cycle_check_unit.sv
